>>> rtl/core/arc_free_path_length_macros.svh
// Assertion macros shared by the core.
`ifndef ARC_FREE_PATH_LENGTH_MACROS_SVH
`define ARC_FREE_PATH_LENGTH_MACROS_SVH

`define AFPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define AFPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/afpl_pkg.sv
package afpl_pkg;

    localparam int CoordW  = 16;
    localparam int RadW    = 20;
    localparam int HwW     = 12;
    localparam int LenW    = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 20;
    localparam int AngW    = 27;
    localparam int CordW   = 34;
    localparam int Steps   = 24;
    localparam int StepW   = 5;
    localparam int D2W     = 41;
    localparam int SqW     = 21;
    localparam int DyW     = 22;
    localparam int MulW    = 21;
    localparam logic [AngW-1:0] AngHalfPi = AngW'(26353589);

    localparam logic [CfgIdxW-1:0] CFG_TURNING = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIRROR  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_RADIUS  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_INNER   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_OUTER   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_HALFW   = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_CAP     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_SQRT, ST_CORDIC, ST_PROD, ST_UPDATE
    } t_state;

    typedef struct packed {
        logic [CoordW-1:0] point_x;
        logic [CoordW-1:0] point_y;
        logic              last_point;
    } t_point;

    typedef struct packed {
        logic [LenW-1:0] free_length;
        logic            obstacle_hit;
    } t_result;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [CfgW-1:0]    data;
    } t_cfg;

    function automatic logic [AngW-1:0] atan_lut(input logic [StepW-1:0] i);
        logic [AngW-1:0] v;
        unique case (i)
            5'd0: v = AngW'(13176795);
            5'd1: v = AngW'(7778716);
            5'd2: v = AngW'(4110060);
            5'd3: v = AngW'(2086331);
            5'd4: v = AngW'(1047214);
            5'd5: v = AngW'(524117);
            5'd6: v = AngW'(262123);
            5'd7: v = AngW'(131069);
            default: v = (i < 5'd24) ? (AngW'(1) << (5'd24 - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/afpl_if.sv
interface afpl_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/arc_free_path_length.sv
// Flow: straight mode, or an arc point dropped at once (x <= 0, zero radius),
//   goes from idle to the update state; arc mode runs squaring, root, CORDIC
//   and product before the update, and leaves the root for the update outside the radii.
// Throughput: one point in flight; a stalled result holds off the input.
// Reset: synchronous active-low; registers load their defaults, running
//   minimum loads the cap, no result pending.
module arc_free_path_length #(
    parameter int COORD_FRAC_BITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    afpl_if.sink   i_point,
    afpl_if.source o_result,
    afpl_if.sink   i_cfg
);
    import afpl_pkg::*;
    `include "arc_free_path_length_macros.svh"

    function automatic logic [CfgW:0] scale(input int v);
        longint s;
        s = (longint'(v) << COORD_FRAC_BITS) >> 10;
        return (CfgW+1)'(s);
    endfunction
    localparam logic [RadW-1:0] RstRad   = RadW'(scale(1024) > 21'hFFFFF ? 21'hFFFFF : scale(1024));
    localparam logic [RadW-1:0] RstInner = RadW'(scale(784) > 21'hFFFFF ? 21'hFFFFF : scale(784));
    localparam logic [RadW-1:0] RstOuter = RadW'(scale(1349) > 21'hFFFFF ? 21'hFFFFF : scale(1349));
    localparam logic [HwW-1:0]  RstHw    = HwW'(scale(246) > 21'hFFF ? 21'hFFF : scale(246));
    localparam logic [LenW-1:0] RstCap   = LenW'(scale(5120) > 21'hFFFF ? 21'hFFFF : scale(5120));

    logic            r_turning, r_mirror;
    logic [RadW-1:0] r_radius, r_inner, r_outer;
    logic [HwW-1:0]  r_halfw;
    logic [LenW-1:0] r_cap, r_min;
    logic            r_hit;

    t_state r_state, n_state;
    logic [5:0] r_cnt;
    logic signed [17:0] r_px;
    logic signed [DyW-1:0] r_dy;
    logic r_last, r_cand_ok, r_arc;
    logic [LenW-1:0] r_cand;
    // shift-add multiplier
    logic [D2W-1:0] r_acc, r_mcand;
    logic [MulW-1:0] r_mplier;
    // root
    logic [D2W+1:0] r_rem;
    logic [SqW-1:0] r_root;
    // cordic
    logic signed [CordW-1:0] r_cx, r_cy;
    logic signed [AngW:0] r_theta;
    // product
    logic [AngW+SqW-1:0] r_prod;
    logic r_out_v;
    t_result r_out;

    assign i_cfg.ready    = 1'b1;
    assign i_point.ready  = (r_state == ST_IDLE) && !r_out_v;
    assign o_result.valid = r_out_v;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turning <= 1'b0; r_mirror <= 1'b0;
            r_radius <= RstRad; r_inner <= RstInner; r_outer <= RstOuter;
            r_halfw <= RstHw; r_cap <= RstCap;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_TURNING: r_turning <= i_cfg.data.data[0];
                CFG_MIRROR:  r_mirror  <= i_cfg.data.data[0];
                CFG_RADIUS:  r_radius  <= i_cfg.data.data;
                CFG_INNER:   r_inner   <= i_cfg.data.data;
                CFG_OUTER:   r_outer   <= i_cfg.data.data;
                CFG_HALFW:   r_halfw   <= i_cfg.data.data[HwW-1:0];
                CFG_CAP:     r_cap     <= i_cfg.data.data[LenW-1:0];
                default: ;
            endcase
        end
    end

    logic point_acc;
    assign point_acc = i_point.valid && i_point.ready;

    // straight test and arc prefilter on the incoming point
    logic signed [17:0] in_x, in_y, in_ym, in_ay;
    assign in_x  = 18'(signed'(i_point.data.point_x));
    assign in_y  = 18'(signed'(i_point.data.point_y));
    assign in_ym = r_mirror ? -in_y : in_y;
    assign in_ay = in_y[17] ? -in_y : in_y;

    // multiplier step
    logic [D2W-1:0]  mul_sum;
    logic [MulW-1:0] dy_mag;
    assign mul_sum = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign dy_mag  = MulW'(r_dy[DyW-1] ? -r_dy : r_dy);

    // root step
    logic [D2W+1:0] sq_trial;
    assign sq_trial = {r_root, 2'b01} << (2 * (6'(SqW-1) - r_cnt));

    logic [D2W:0] d2_lo, d2_hi;
    logic         d2_in;
    assign d2_lo = (D2W+1)'(r_inner) * (D2W+1)'(r_inner);
    assign d2_hi = (D2W+1)'(r_outer) * (D2W+1)'(r_outer);
    assign d2_in = ((D2W+1)'(r_acc) >= d2_lo) && ((D2W+1)'(r_acc) <= d2_hi);

    logic signed [CordW-1:0] sh_x, sh_y;
    assign sh_x = r_cx >>> r_cnt[StepW-1:0];
    assign sh_y = r_cy >>> r_cnt[StepW-1:0];

    logic [AngW-1:0] ang_pos;
    assign ang_pos = r_theta[AngW] ? '0 : r_theta[AngW-1:0];

    // rounded, saturated arc length and the candidate of this point
    logic [AngW+SqW-1:0] prod_rnd;
    logic [LenW-1:0]     arc_len, cand_len;
    logic                better;
    assign prod_rnd = r_prod + ((AngW+SqW)'(1) << 23);
    assign arc_len  = (|prod_rnd[AngW+SqW-1:24+LenW]) ? '1 : prod_rnd[24+LenW-1:24];
    assign cand_len = r_arc ? arc_len : r_cand;
    assign better   = r_cand_ok && (cand_len < r_min);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (point_acc) n_state = (r_turning && in_x > 0 && r_radius != '0)
                                                ? ST_MUL : ST_UPDATE;
            ST_MUL:    if (r_cnt == 6'(2*MulW-1)) n_state = ST_SQRT;
            ST_SQRT:   if (r_cnt == 6'(SqW-1)) n_state = d2_in ? ST_CORDIC : ST_UPDATE;
            ST_CORDIC: if (r_cnt == 6'(Steps-1)) n_state = ST_PROD;
            ST_PROD:   if (r_cnt == 6'(SqW-1)) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_cnt <= '0; r_out_v <= 1'b0;
            r_min <= RstCap; r_hit <= 1'b0; r_cand_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_result.valid && o_result.ready) r_out_v <= 1'b0;
                    if (point_acc) begin
                        r_px <= in_x; r_dy <= DyW'(in_ym) - DyW'(r_radius);
                        r_last <= i_point.data.last_point;
                        r_arc <= r_turning;
                        r_cand <= i_point.data.point_x;
                        r_cand_ok <= !r_turning && in_x > 0 && in_ay < 18'(r_halfw);
                        r_cnt <= '0;
                        r_acc <= '0;
                        r_mcand  <= D2W'(i_point.data.point_x);
                        r_mplier <= MulW'(i_point.data.point_x);
                    end
                end
                ST_MUL: begin
                    // x squared, then (y - R) squared with y mirrored when set, one multiplier bit a cycle
                    r_acc <= mul_sum;
                    if (r_cnt == 6'(MulW-1)) begin
                        r_mcand  <= D2W'(dy_mag);
                        r_mplier <= dy_mag;
                    end else begin
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                    if (r_cnt == 6'(2*MulW-1)) begin
                        r_cnt <= '0; r_root <= '0;
                        r_rem <= (D2W+2)'(mul_sum);
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_SQRT: begin
                    if (r_rem >= sq_trial) begin
                        r_rem <= r_rem - sq_trial; r_root <= {r_root[SqW-2:0], 1'b1};
                    end else r_root <= {r_root[SqW-2:0], 1'b0};
                    if (r_cnt == 6'(SqW-1)) begin
                        r_cnt <= '0;
                        r_cand_ok <= d2_in;
                        if (r_dy > 0) begin
                            r_cx <= CordW'(r_px) <<< 8;
                            r_cy <= CordW'(r_dy) <<< 8;
                            r_theta <= (AngW+1)'(AngHalfPi);
                        end else begin
                            r_cx <= CordW'(-r_dy) <<< 8;
                            r_cy <= CordW'(r_px) <<< 8;
                            r_theta <= '0;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_CORDIC: begin
                    if (r_cy > 0) begin
                        r_cx <= r_cx + sh_y; r_cy <= r_cy - sh_x;
                        r_theta <= r_theta + (AngW+1)'(atan_lut(r_cnt[StepW-1:0]));
                    end else begin
                        r_cx <= r_cx - sh_y; r_cy <= r_cy + sh_x;
                        r_theta <= r_theta - (AngW+1)'(atan_lut(r_cnt[StepW-1:0]));
                    end
                    if (r_cnt == 6'(Steps-1)) begin
                        r_cnt <= '0; r_prod <= '0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                ST_PROD: begin
                    if (r_root[r_cnt[StepW-1:0]])
                        r_prod <= r_prod + ((AngW+SqW)'(ang_pos) << r_cnt[StepW-1:0]);
                    r_cnt <= r_cnt + 6'd1;
                end
                ST_UPDATE: begin
                    if (r_last) begin
                        r_out.free_length  <= better ? cand_len : r_min;
                        r_out.obstacle_hit <= better | r_hit;
                        r_out_v <= 1'b1;
                        r_min <= r_cap; r_hit <= 1'b0;
                    end else if (better) begin
                        r_min <= cand_len; r_hit <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    `AFPL_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !i_point.ready)
    `AFPL_ASSERT_NXT(a_result_after_last, i_clk, i_rst_n, r_state == ST_UPDATE && r_last, r_out_v)
    `AFPL_ASSERT_NXT(a_result_held, i_clk, i_rst_n, r_out_v && !o_result.ready, r_out_v && $stable(r_out))
endmodule
